// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/pdc_pkg.sv
// Shared types and constants of the PID duty controller.
// No dependencies; used by every module of the block.
package pdc_pkg;

    localparam int TEMP_W             = 16;
    localparam int TEMP_FRAC_BITS     = 4;
    localparam int GAIN_W             = 32;
    localparam int GAIN_FRACTION_BITS = 16;
    localparam int PERIOD_W           = 16;
    localparam int DUTY_W             = 7;
    localparam int CMP_W              = 16;
    localparam int CFG_DATA_W         = 32;
    localparam int CFG_INDEX_W        = 3;

    localparam int ERR_W   = TEMP_W + 1;
    localparam int DERIV_W = TEMP_W + 2;
    localparam int INTEG_W = 32;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = 64;

    // Sum is in Q.(4+GAIN_FRACTION_BITS); whole percent sits above this point.
    localparam int DUTY_SHIFT = TEMP_FRAC_BITS + GAIN_FRACTION_BITS;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
    localparam logic signed [SUM_W-1:0] DUTY_TOP = 64'sd100 <<< DUTY_SHIFT;
    localparam logic signed [PROD_W-1:0] TERM_LIMIT = 66'sd1 <<< 60;

    // floor(x / 100) = (x * ceil(2^32 / 100)) >> 32 for x below 2^23.
    localparam int RECIP_SHIFT = 32;
    localparam int CMP_PROD_W  = 23;
    localparam logic [MUL_W-1:0] CMP_RECIP = 33'd42949673;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KI      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KD      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD  = 3'd4;

    localparam logic signed [TEMP_W-1:0] RST_TARGET = 16'sd3200;
    localparam logic [GAIN_W-1:0]        RST_KP     = 32'd327680;
    localparam logic [GAIN_W-1:0]        RST_KI     = 32'd66;
    localparam logic [GAIN_W-1:0]        RST_KD     = 32'd6553600;
    localparam logic [PERIOD_W-1:0]      RST_PERIOD = 16'd44999;

    typedef struct packed {
        logic signed [TEMP_W-1:0] target;
        logic [GAIN_W-1:0]        kp;
        logic [GAIN_W-1:0]        ki;
        logic [GAIN_W-1:0]        kd;
        logic [PERIOD_W-1:0]      period;
    } pdc_cfg_t;

    // Datapath commands, one per controller step.
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_ERR   = 4'd2,
        OP_MUL_P = 4'd3,
        OP_MUL_I = 4'd4,
        OP_MUL_D = 4'd5,
        OP_SUM   = 4'd6,
        OP_MUL_C = 4'd7,
        OP_MUL_R = 4'd8,
        OP_OUT   = 4'd9
    } pdc_op_t;

    typedef struct packed {
        logic out_busy;
        logic out_valid;
    } pdc_status_t;

endpackage

// File: rtl/pid_duty_controller_top.sv
// Top level of the PID duty controller: configuration registers, sequencer
// and datapath. Depends on pdc_pkg, pdc_cfg, pdc_ctrl, pdc_dp, assert_macros.svh.
//
// Each item is one measured temperature (signed Q12.4 degrees). The block
// forms error = target - measurement, adds it to an integral that saturates
// at signed 32 bits, takes the derivative against the previous error, and
// sums Kp*P + Ki*I + Kd*D with unsigned Q16.16 gains, the integral term
// limited to +-2^60. The sum is clamped to 0..100 percent and truncated to a
// whole percent; the compare value is floor(duty * pwm_period / 100), done
// as a multiply by a reciprocal. After the accept edge a sequencer runs eight
// steps (error, P, I, D, sum, compare, reciprocal, output), one per cycle
// unless the output step stalls; the output step registers the result, and
// a new item is accepted once the sequencer is idle. All products (P, I, D,
// duty times period, reciprocal) go through a single shared 33x33 signed
// multiplier with its product registered. Items are processed one at a time;
// s_ready is high only while the sequencer is idle and out of reset. The
// result sits in an output register, so the next item starts while it
// waits; that item stalls in its last step until the earlier result is
// taken. Registers are written through cfg_we/cfg_index/cfg_wdata with no
// wait and should change only while no item is in flight; an unknown
// index is ignored. Reset restores the default gains and clears the
// integral and previous error.
`include "assert_macros.svh"

module pid_duty_controller_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [pdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // measurement input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pdc_pkg::TEMP_W-1:0]   s_measured_temperature,
    // duty result
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pdc_pkg::DUTY_W-1:0]          m_duty_percent,
    output logic [pdc_pkg::CMP_W-1:0]           m_compare_value
);

    pdc_pkg::pdc_cfg_t    cfg;
    pdc_pkg::pdc_op_t     op;
    pdc_pkg::pdc_status_t status;

    // Register file: target, gains and PWM period.
    pdc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Sequencer: accept an item, then issue one datapath command per cycle unless the output step stalls.
    pdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .op      (op)
    );

    // Datapath: loop state, shared multiplier, accumulator, output register.
    pdc_dp u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg                    (cfg),
        .op                     (op),
        .status                 (status),
        .s_measured_temperature (s_measured_temperature),
        .m_ready                (m_ready),
        .m_valid                (m_valid),
        .m_duty_percent         (m_duty_percent),
        .m_compare_value        (m_compare_value)
    );

    // One item at a time: an accept is never followed directly by another.
    `ASSERT_PROP(a_one_item, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "second item accepted while busy")
    // Duty never leaves 0..100.
    `ASSERT_NEVER(a_duty_range, aclk, aresetn, m_valid && (m_duty_percent > pdc_pkg::DUTY_MAX), "duty above 100 percent")
    // Zero duty gives a zero compare value.
    `ASSERT_PROP(a_zero_cmp, aclk, aresetn, (m_valid && (m_duty_percent == '0)) |-> (m_compare_value == '0), "nonzero compare at zero duty")
    // Sequencer only issues the output step when the output register is free.
    `ASSERT_NEVER(a_out_overrun, aclk, aresetn, (op == pdc_pkg::OP_OUT) && status.out_busy, "result overwritten before taken")

endmodule

// File: rtl/pdc_cfg.sv
// Configuration register file of the PID duty controller.
// Depends on pdc_pkg.
module pdc_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [pdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output pdc_pkg::pdc_cfg_t                  cfg
);

    pdc_pkg::pdc_cfg_t cfg_reg;
    pdc_pkg::pdc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                pdc_pkg::REG_TARGET: cfg_next.target = $signed(cfg_wdata[pdc_pkg::TEMP_W-1:0]);
                pdc_pkg::REG_KP:     cfg_next.kp     = cfg_wdata[pdc_pkg::GAIN_W-1:0];
                pdc_pkg::REG_KI:     cfg_next.ki     = cfg_wdata[pdc_pkg::GAIN_W-1:0];
                pdc_pkg::REG_KD:     cfg_next.kd     = cfg_wdata[pdc_pkg::GAIN_W-1:0];
                pdc_pkg::REG_PERIOD: cfg_next.period = cfg_wdata[pdc_pkg::PERIOD_W-1:0];
                default:             cfg_next = cfg_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target <= pdc_pkg::RST_TARGET;
            cfg_reg.kp     <= pdc_pkg::RST_KP;
            cfg_reg.ki     <= pdc_pkg::RST_KI;
            cfg_reg.kd     <= pdc_pkg::RST_KD;
            cfg_reg.period <= pdc_pkg::RST_PERIOD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/pdc_ctrl.sv
// Sequencer of the PID duty controller: steps one item through the datapath.
// Depends on pdc_pkg.
module pdc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pdc_pkg::pdc_status_t  status,
    output pdc_pkg::pdc_op_t      op
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ERR   = 9'b000000010,
        ST_MUL_P = 9'b000000100,
        ST_MUL_I = 9'b000001000,
        ST_MUL_D = 9'b000010000,
        ST_SUM   = 9'b000100000,
        ST_MUL_C = 9'b001000000,
        ST_MUL_R = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        op         = pdc_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                // hold off items while in reset
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    op         = pdc_pkg::OP_LOAD;
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                op         = pdc_pkg::OP_ERR;
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                op         = pdc_pkg::OP_MUL_P;
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                op         = pdc_pkg::OP_MUL_I;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                op         = pdc_pkg::OP_MUL_D;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                op         = pdc_pkg::OP_SUM;
                state_next = ST_MUL_C;
            end
            ST_MUL_C: begin
                op         = pdc_pkg::OP_MUL_C;
                state_next = ST_MUL_R;
            end
            ST_MUL_R: begin
                op         = pdc_pkg::OP_MUL_R;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!status.out_busy) begin
                    op         = pdc_pkg::OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/pdc_dp.sv
// Datapath of the PID duty controller: loop state, shared multiplier,
// accumulator and output register. Depends on pdc_pkg.
module pdc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pdc_pkg::pdc_cfg_t                   cfg,
    input  pdc_pkg::pdc_op_t                    op,
    output pdc_pkg::pdc_status_t                status,
    input  logic signed [pdc_pkg::TEMP_W-1:0]   s_measured_temperature,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [pdc_pkg::DUTY_W-1:0]          m_duty_percent,
    output logic [pdc_pkg::CMP_W-1:0]           m_compare_value
);

    logic signed [pdc_pkg::TEMP_W-1:0]  meas_reg;
    logic signed [pdc_pkg::INTEG_W-1:0] integ_reg;
    logic signed [pdc_pkg::ERR_W-1:0]   prev_err_reg;
    logic signed [pdc_pkg::DERIV_W-1:0] deriv_reg;
    logic signed [pdc_pkg::PROD_W-1:0]  prod_reg;
    logic signed [pdc_pkg::SUM_W-1:0]   acc_reg;
    logic [pdc_pkg::DUTY_W-1:0]         duty_reg;
    logic                               out_valid_reg;
    logic [pdc_pkg::DUTY_W-1:0]         out_duty_reg;
    logic [pdc_pkg::CMP_W-1:0]          out_cmp_reg;

    logic signed [pdc_pkg::ERR_W-1:0]     err_w;
    logic signed [pdc_pkg::INTEG_W:0]     integ_full;
    logic signed [pdc_pkg::INTEG_W-1:0]   integ_sat;
    logic signed [pdc_pkg::DERIV_W-1:0]   deriv_w;
    logic signed [pdc_pkg::MUL_W-1:0]     mul_a;
    logic signed [pdc_pkg::MUL_W-1:0]     mul_b;
    logic signed [pdc_pkg::PROD_W-1:0]    mul_p;
    logic signed [pdc_pkg::SUM_W-1:0]     ti_clamped;
    logic signed [pdc_pkg::SUM_W-1:0]     sum_w;
    logic [pdc_pkg::DUTY_W-1:0]           duty_w;
    logic                                 mul_en;

    // Error, saturated integral and derivative.
    always_comb begin
        err_w = $signed({cfg.target[pdc_pkg::TEMP_W-1], cfg.target})
              - $signed({meas_reg[pdc_pkg::TEMP_W-1], meas_reg});
        integ_full = $signed({integ_reg[pdc_pkg::INTEG_W-1], integ_reg})
                   + $signed({{(pdc_pkg::INTEG_W + 1 - pdc_pkg::ERR_W){err_w[pdc_pkg::ERR_W-1]}},
                              err_w});
        if (integ_full[pdc_pkg::INTEG_W] != integ_full[pdc_pkg::INTEG_W-1]) begin
            integ_sat = integ_full[pdc_pkg::INTEG_W]
                      ? $signed({1'b1, {(pdc_pkg::INTEG_W-1){1'b0}}})
                      : $signed({1'b0, {(pdc_pkg::INTEG_W-1){1'b1}}});
        end else begin
            integ_sat = integ_full[pdc_pkg::INTEG_W-1:0];
        end
        deriv_w = $signed({err_w[pdc_pkg::ERR_W-1], err_w})
                - $signed({prev_err_reg[pdc_pkg::ERR_W-1], prev_err_reg});
    end

    // Shared multiplier operand select.
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (op)
            pdc_pkg::OP_MUL_P: begin
                mul_a = $signed({{(pdc_pkg::MUL_W - pdc_pkg::ERR_W){prev_err_reg[pdc_pkg::ERR_W-1]}},
                                 prev_err_reg});
                mul_b = $signed({1'b0, cfg.kp});
            end
            pdc_pkg::OP_MUL_I: begin
                mul_a = $signed({integ_reg[pdc_pkg::INTEG_W-1], integ_reg});
                mul_b = $signed({1'b0, cfg.ki});
            end
            pdc_pkg::OP_MUL_D: begin
                mul_a = $signed({{(pdc_pkg::MUL_W - pdc_pkg::DERIV_W){deriv_reg[pdc_pkg::DERIV_W-1]}},
                                 deriv_reg});
                mul_b = $signed({1'b0, cfg.kd});
            end
            pdc_pkg::OP_MUL_C: begin
                mul_a = $signed({{(pdc_pkg::MUL_W - pdc_pkg::DUTY_W){1'b0}}, duty_reg});
                mul_b = $signed({{(pdc_pkg::MUL_W - pdc_pkg::PERIOD_W){1'b0}}, cfg.period});
            end
            pdc_pkg::OP_MUL_R: begin
                mul_a = $signed({{(pdc_pkg::MUL_W - pdc_pkg::CMP_PROD_W){1'b0}},
                                 prod_reg[pdc_pkg::CMP_PROD_W-1:0]});
                mul_b = $signed(pdc_pkg::CMP_RECIP);
            end
            default: mul_en = 1'b0;
        endcase
        mul_p = mul_a * mul_b;
    end

    // Integral term limit, final sum and duty clamp.
    always_comb begin
        priority if (prod_reg > pdc_pkg::TERM_LIMIT) begin
            ti_clamped = pdc_pkg::TERM_LIMIT[pdc_pkg::SUM_W-1:0];
        end else if (prod_reg < -pdc_pkg::TERM_LIMIT) begin
            ti_clamped = -pdc_pkg::TERM_LIMIT[pdc_pkg::SUM_W-1:0];
        end else begin
            ti_clamped = prod_reg[pdc_pkg::SUM_W-1:0];
        end
        sum_w = acc_reg + prod_reg[pdc_pkg::SUM_W-1:0];
        priority if (sum_w <= 0) begin
            duty_w = '0;
        end else if (sum_w >= pdc_pkg::DUTY_TOP) begin
            duty_w = pdc_pkg::DUTY_MAX;
        end else begin
            duty_w = sum_w[pdc_pkg::DUTY_SHIFT +: pdc_pkg::DUTY_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_p;
        end
        unique case (op)
            pdc_pkg::OP_LOAD:  meas_reg <= s_measured_temperature;
            pdc_pkg::OP_ERR:   deriv_reg <= deriv_w;
            pdc_pkg::OP_MUL_P: acc_reg <= '0;
            pdc_pkg::OP_MUL_I: acc_reg <= prod_reg[pdc_pkg::SUM_W-1:0];
            pdc_pkg::OP_MUL_D: acc_reg <= acc_reg + ti_clamped;
            pdc_pkg::OP_SUM:   duty_reg <= duty_w;
            pdc_pkg::OP_OUT: begin
                out_duty_reg <= duty_reg;
                out_cmp_reg  <= prod_reg[pdc_pkg::RECIP_SHIFT +: pdc_pkg::CMP_W];
            end
            default: ;
        endcase
    end

    // Loop state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (op == pdc_pkg::OP_ERR) begin
                integ_reg    <= integ_sat;
                prev_err_reg <= err_w;
            end
            if (op == pdc_pkg::OP_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy  = out_valid_reg && !m_ready;
    assign status.out_valid = out_valid_reg;
    assign m_valid          = out_valid_reg;
    assign m_duty_percent   = out_duty_reg;
    assign m_compare_value  = out_cmp_reg;

endmodule
